[design/swmt_pkg.sv]
// Shared constants and types for the windowed SPI master transfer block.
`default_nettype none
package swmt_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int INDEX_WIDTH   = COUNT_WIDTH + 1;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(7);
    localparam logic [BIT_W-1:0] FIRST_BIT = '0;

    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_OUT_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_OFFSET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IN_COUNT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TX_ENABLE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RX_ENABLE = 3'd4;

    localparam logic ACTION_START = 1'b0;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] out_count;
        logic [COUNT_WIDTH-1:0] in_offset;
        logic [COUNT_WIDTH-1:0] in_count;
        logic                   tx_enable;
        logic                   rx_enable;
    } cfg_t;

    typedef struct packed {
        logic                   mosi;
        logic                   cs_n;
        logic                   rx_valid;
        logic [7:0]             rx_byte;
        logic [COUNT_WIDTH-1:0] rx_index;
        logic                   tx_taken;
        logic                   done_res;
        logic                   rejected;
    } res_t;

endpackage
`default_nettype wire

[design/spi_master_windowed_transfer.sv]
// Top level of the windowed SPI master transfer block (mode 0, MSB first).
//
// Each input transfer is either a start or one SPI bit period and yields exactly
// one result transfer. Items are taken one per clock: the transfer state updates
// at acceptance and the result lands in a single output register, so the input
// keeps moving whenever the result register is empty or being drained.
// Configuration is written over APB at byte address 4*i and should change only
// while no item is in flight.
`default_nettype none
module spi_master_windowed_transfer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [swmt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic                        s_action,
    input  wire logic [7:0]                  s_tx_byte,
    input  wire logic                        s_miso,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic                        m_mosi,
    output      logic                        m_cs_n,
    output      logic                        m_rx_valid,
    output      logic [7:0]                  m_rx_byte,
    output      logic [swmt_pkg::COUNT_WIDTH-1:0] m_rx_index,
    output      logic                        m_tx_taken,
    output      logic                        m_done_res,
    output      logic                        m_rejected
);

    swmt_pkg::cfg_t cfg;
    swmt_pkg::res_t res_c;
    swmt_pkg::res_t res_q;
    logic           step;

    swmt_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign step = s_valid & s_ready;

    swmt_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .action  (s_action),
        .tx_byte (s_tx_byte),
        .miso    (s_miso),
        .res     (res_c)
    );

    swmt_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res_in   (res_c),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .can_load (s_ready),
        .res_out  (res_q)
    );

    assign m_mosi     = res_q.mosi;
    assign m_cs_n     = res_q.cs_n;
    assign m_rx_valid = res_q.rx_valid;
    assign m_rx_byte  = res_q.rx_byte;
    assign m_rx_index = res_q.rx_index;
    assign m_tx_taken = res_q.tx_taken;
    assign m_done_res = res_q.done_res;
    assign m_rejected = res_q.rejected;

    a_done_raises_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> m_cs_n)
        else $error("done result with chip select still low");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected) |-> (!m_done_res && !m_rx_valid && !m_tx_taken && !m_mosi))
        else $error("rejected start carries transfer activity");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted item produced no result");

endmodule
`default_nettype wire

[design/swmt_apb_regs.sv]
// APB configuration registers for the windowed SPI master transfer block.
`default_nettype none
module swmt_apb_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [swmt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready,
    output      swmt_pkg::cfg_t              cfg
);

    swmt_pkg::cfg_t                     cfg_reg;
    logic [swmt_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                               wr_en;

    assign reg_idx = paddr[swmt_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                swmt_pkg::REG_OUT_COUNT:
                    cfg_reg.out_count <= pwdata[swmt_pkg::COUNT_WIDTH-1:0];
                swmt_pkg::REG_IN_OFFSET:
                    cfg_reg.in_offset <= pwdata[swmt_pkg::COUNT_WIDTH-1:0];
                swmt_pkg::REG_IN_COUNT:
                    cfg_reg.in_count  <= pwdata[swmt_pkg::COUNT_WIDTH-1:0];
                swmt_pkg::REG_TX_ENABLE: cfg_reg.tx_enable <= pwdata[0];
                swmt_pkg::REG_RX_ENABLE: cfg_reg.rx_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            swmt_pkg::REG_OUT_COUNT:
                prdata = 32'(cfg_reg.out_count);
            swmt_pkg::REG_IN_OFFSET:
                prdata = 32'(cfg_reg.in_offset);
            swmt_pkg::REG_IN_COUNT:
                prdata = 32'(cfg_reg.in_count);
            swmt_pkg::REG_TX_ENABLE: prdata = {31'd0, cfg_reg.tx_enable};
            swmt_pkg::REG_RX_ENABLE: prdata = {31'd0, cfg_reg.rx_enable};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[design/swmt_engine.sv]
// Transfer state and per-item bit logic of the windowed SPI master.
`default_nettype none
module swmt_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire swmt_pkg::cfg_t cfg,
    input  wire logic           step,
    input  wire logic           action,
    input  wire logic [7:0]     tx_byte,
    input  wire logic           miso,
    output      swmt_pkg::res_t res
);

    localparam int IW = swmt_pkg::INDEX_WIDTH;
    localparam int BW = swmt_pkg::BIT_W;

    logic          active_reg,     active_next;
    logic [IW-1:0] byte_index_reg, byte_index_next;
    logic [IW-1:0] byte_total_reg, byte_total_next;
    logic [BW-1:0] bit_index_reg,  bit_index_next;
    logic [7:0]    out_shift_reg,  out_shift_next;
    logic [7:0]    in_shift_reg,   in_shift_next;

    always_comb begin
        logic [IW-1:0] win_end;
        logic [IW-1:0] out_cnt_x;
        logic [IW-1:0] off_x;
        logic [IW-1:0] total;
        logic [IW-1:0] idx_inc;
        logic [IW-1:0] rel;
        logic [7:0]    shift_src;
        logic [7:0]    in_new;

        out_cnt_x = IW'(cfg.out_count);
        off_x     = IW'(cfg.in_offset);
        win_end   = off_x + IW'(cfg.in_count);
        idx_inc   = byte_index_reg + IW'(1);
        rel       = byte_index_reg - off_x;
        in_new    = {in_shift_reg[6:0], miso};
        total     = '0;
        shift_src = '0;

        active_next     = active_reg;
        byte_index_next = byte_index_reg;
        byte_total_next = byte_total_reg;
        bit_index_next  = bit_index_reg;
        out_shift_next  = out_shift_reg;
        in_shift_next   = in_shift_reg;
        res             = '0;

        if (action == swmt_pkg::ACTION_START) begin
            if (!cfg.tx_enable && !cfg.rx_enable) begin
                res.rejected = 1'b1;
            end else begin
                if (cfg.tx_enable && cfg.rx_enable) begin
                    total = (win_end > out_cnt_x) ? win_end : out_cnt_x;
                end else if (cfg.tx_enable) begin
                    total = out_cnt_x;
                end else begin
                    total = win_end;
                end
                byte_total_next = total;
                byte_index_next = '0;
                bit_index_next  = '0;
                out_shift_next  = '0;
                in_shift_next   = '0;
                active_next     = (total != '0);
                res.done_res    = (total == '0);
            end
        end else if (active_reg) begin
            // at the head of each byte, load a fresh transmit byte while one is due, else zeros
            if (bit_index_reg == swmt_pkg::FIRST_BIT) begin
                if (cfg.tx_enable && byte_index_reg < out_cnt_x) begin
                    shift_src    = tx_byte;
                    res.tx_taken = 1'b1;
                end
            end else begin
                shift_src = out_shift_reg;
            end
            res.mosi       = shift_src[7];
            out_shift_next = {shift_src[6:0], 1'b0};
            in_shift_next  = in_new;
            if (bit_index_reg == swmt_pkg::LAST_BIT) begin
                if (cfg.rx_enable && byte_index_reg >= off_x && byte_index_reg < win_end) begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = in_new;
                    res.rx_index = rel[swmt_pkg::COUNT_WIDTH-1:0];
                end
                bit_index_next  = '0;
                byte_index_next = idx_inc;
                if (idx_inc >= byte_total_reg) begin
                    active_next  = 1'b0;
                    res.done_res = 1'b1;
                end
            end else begin
                bit_index_next = bit_index_reg + BW'(1);
            end
        end
        res.cs_n = !active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            byte_index_reg <= '0;
            byte_total_reg <= '0;
            bit_index_reg  <= '0;
            out_shift_reg  <= '0;
            in_shift_reg   <= '0;
        end else if (step) begin
            active_reg     <= active_next;
            byte_index_reg <= byte_index_next;
            byte_total_reg <= byte_total_next;
            bit_index_reg  <= bit_index_next;
            out_shift_reg  <= out_shift_next;
            in_shift_reg   <= in_shift_next;
        end
    end

endmodule
`default_nettype wire

[design/swmt_out_reg.sv]
// Result register with valid/ready handshake for the windowed SPI master.
`default_nettype none
module swmt_out_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire swmt_pkg::res_t res_in,
    input  wire logic           m_ready,
    output      logic           m_valid,
    output      logic           can_load,
    output      swmt_pkg::res_t res_out
);

    logic           valid_reg;
    swmt_pkg::res_t data_reg;

    // accept a new result when empty, or while the held one leaves in the same cycle
    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = data_reg;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the windowed SPI master transfer block.
`timescale 1ns / 100ps
module tb_top;

    localparam logic ACTION_BIT = ~swmt_pkg::ACTION_START;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   RANDOM_ITEMS = 600;
    localparam int   IW = swmt_pkg::INDEX_WIDTH;
    localparam int   CW = swmt_pkg::COUNT_WIDTH;

    typedef struct packed {
        logic       action;
        logic [7:0] tx_byte;
        logic       miso;
    } spi_item_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [swmt_pkg::ADDR_W-1:0]     paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_action = swmt_pkg::ACTION_START;
    logic [7:0]                      s_tx_byte = '0;
    logic                            s_miso = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_mosi;
    logic                            m_cs_n;
    logic                            m_rx_valid;
    logic [7:0]                      m_rx_byte;
    logic [swmt_pkg::COUNT_WIDTH-1:0] m_rx_index;
    logic                            m_tx_taken;
    logic                            m_done_res;
    logic                            m_rejected;

    spi_master_windowed_transfer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_tx_byte  (s_tx_byte),
        .s_miso     (s_miso),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mosi     (m_mosi),
        .m_cs_n     (m_cs_n),
        .m_rx_valid (m_rx_valid),
        .m_rx_byte  (m_rx_byte),
        .m_rx_index (m_rx_index),
        .m_tx_taken (m_tx_taken),
        .m_done_res (m_done_res),
        .m_rejected (m_rejected)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the block: register copy plus the shifter and counter state.
    swmt_pkg::cfg_t              shadow_cfg = '0;
    logic                        link_active = 1'b0;
    logic [IW-1:0]               link_byte = '0;
    logic [IW-1:0]               link_total = '0;
    logic [swmt_pkg::BIT_W-1:0]  link_bit = swmt_pkg::FIRST_BIT;
    logic [7:0]                  tx_shift = '0;
    logic [7:0]                  rx_shift = '0;

    spi_item_t      bits_to_send[$];
    swmt_pkg::res_t expected_pins[$];
    spi_item_t      on_bus = '0;

    int items_issued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int error_count = 0;
    int cycle_count = 0;
    int config_writes = 0;
    int window_bytes = 0;
    int tx_bytes_taken = 0;
    int transfers_done = 0;
    int starts_refused = 0;

    function automatic logic [IW-1:0] transfer_bytes(input swmt_pkg::cfg_t c);
        logic [IW-1:0] win_end;
        win_end = IW'(c.in_offset) + IW'(c.in_count);
        if (c.tx_enable && c.rx_enable)
            return (win_end > IW'(c.out_count)) ? win_end : IW'(c.out_count);
        else if (c.tx_enable)
            return IW'(c.out_count);
        else if (c.rx_enable)
            return win_end;
        return '0;
    endfunction

    task automatic advance_spi_link(input spi_item_t it, output swmt_pkg::res_t r);
        logic [IW-1:0] win_end;
        logic [IW-1:0] total;
        r = '0;
        win_end = IW'(shadow_cfg.in_offset) + IW'(shadow_cfg.in_count);
        if (it.action == swmt_pkg::ACTION_START) begin
            if (!shadow_cfg.tx_enable && !shadow_cfg.rx_enable) begin
                // refused start leaves any running transfer alone
                r.rejected = 1'b1;
            end else begin
                total = transfer_bytes(shadow_cfg);
                link_total = total;
                link_byte = '0;
                link_bit = swmt_pkg::FIRST_BIT;
                tx_shift = '0;
                rx_shift = '0;
                link_active = (total != '0);
                r.done_res = (total == '0);
            end
        end else if (link_active) begin
            if (link_bit == swmt_pkg::FIRST_BIT) begin
                if (shadow_cfg.tx_enable && link_byte < IW'(shadow_cfg.out_count)) begin
                    tx_shift = it.tx_byte;
                    r.tx_taken = 1'b1;
                end else begin
                    tx_shift = '0;
                end
            end
            r.mosi = tx_shift[7];
            tx_shift = {tx_shift[6:0], 1'b0};
            rx_shift = {rx_shift[6:0], it.miso};
            if (link_bit == swmt_pkg::LAST_BIT) begin
                if (shadow_cfg.rx_enable && link_byte >= IW'(shadow_cfg.in_offset)
                        && link_byte < win_end) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = rx_shift;
                    r.rx_index = CW'(link_byte - IW'(shadow_cfg.in_offset));
                end
                link_bit = swmt_pkg::FIRST_BIT;
                link_byte = link_byte + 1'b1;
                if (link_byte >= link_total) begin
                    link_active = 1'b0;
                    r.done_res = 1'b1;
                end
            end else begin
                link_bit = link_bit + 1'b1;
            end
        end
        r.cs_n = !link_active;
    endtask

    // Input side: present queued items, idle at random outside the calm stretch.
    always @(posedge aclk) begin
        swmt_pkg::res_t predicted;
        spi_item_t      nxt;
        logic           calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_spi_link(on_bus, predicted);
                expected_pins.push_back(predicted);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                calm = (items_accepted >= 200 && items_accepted < 330);
                if (bits_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
                    nxt = bits_to_send.pop_front();
                    on_bus = nxt;
                    s_valid <= 1'b1;
                    s_action <= nxt.action;
                    s_tx_byte <= nxt.tx_byte;
                    s_miso <= nxt.miso;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Result side: stall at random and compare every transfer in order.
    always @(posedge aclk) begin
        swmt_pkg::res_t want;
        logic           calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_pins.size() == 0) begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("mosi", want.mosi, m_mosi);
                    check_field("cs_n", want.cs_n, m_cs_n);
                    check_field("rx_valid", want.rx_valid, m_rx_valid);
                    check_field("rx_byte", want.rx_byte, m_rx_byte);
                    check_field("rx_index", want.rx_index, m_rx_index);
                    check_field("tx_taken", want.tx_taken, m_tx_taken);
                    check_field("done_res", want.done_res, m_done_res);
                    check_field("rejected", want.rejected, m_rejected);
                    window_bytes += want.rx_valid;
                    tx_bytes_taken += want.tx_taken;
                    transfers_done += want.done_res;
                    starts_refused += want.rejected;
                end
            end
            calm = (results_checked >= 200 && results_checked < 330);
            m_ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic push_item(input logic action, input logic [7:0] txb, input logic miso);
        bits_to_send.push_back('{action: action, tx_byte: txb, miso: miso});
        items_issued++;
    endtask

    task automatic wait_for_results;
        while (items_issued != results_checked)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [swmt_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            swmt_pkg::REG_OUT_COUNT: shadow_cfg.out_count = value[CW-1:0];
            swmt_pkg::REG_IN_OFFSET: shadow_cfg.in_offset = value[CW-1:0];
            swmt_pkg::REG_IN_COUNT:  shadow_cfg.in_count = value[CW-1:0];
            swmt_pkg::REG_TX_ENABLE: shadow_cfg.tx_enable = value[0];
            swmt_pkg::REG_RX_ENABLE: shadow_cfg.rx_enable = value[0];
            default: ;
        endcase
        config_writes++;
    endtask

    function automatic logic [31:0] pick_count(input int unsigned top);
        if ($urandom_range(0, 11) == 0)
            return 32'h0000_FFFF;
        return $urandom_range(0, top);
    endfunction

    initial begin
        int counted;
        int n_bits;
        int n_xfers;
        int total_bytes;
        counted = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers at reset: stray bit while idle, then a start with both sides off.
        push_item(ACTION_BIT, 8'hFF, 1'b1);
        push_item(swmt_pkg::ACTION_START, 8'h00, 1'b0);
        wait_for_results;

        // Transmit only with nothing to send: finishes at the start.
        write_reg(swmt_pkg::REG_TX_ENABLE, 32'd1);
        push_item(swmt_pkg::ACTION_START, 8'hFF, 1'b1);
        wait_for_results;

        // Receive only, window is byte 1: open and run half of byte 0.
        write_reg(swmt_pkg::REG_TX_ENABLE, 32'd0);
        write_reg(swmt_pkg::REG_RX_ENABLE, 32'd1);
        write_reg(swmt_pkg::REG_IN_OFFSET, 32'd1);
        write_reg(swmt_pkg::REG_IN_COUNT, 32'd1);
        push_item(swmt_pkg::ACTION_START, 8'h00, 1'b0);
        for (int i = 0; i < 4; i++)
            push_item(ACTION_BIT, 8'hFF, i[0]);
        wait_for_results;

        // Both sides off mid-transfer: start is refused, chip select stays low.
        write_reg(swmt_pkg::REG_RX_ENABLE, 32'd0);
        push_item(swmt_pkg::ACTION_START, 8'hFF, 1'b1);
        wait_for_results;

        // Re-enable with transmit on: new values apply at once, total stays 2.
        write_reg(swmt_pkg::REG_RX_ENABLE, 32'd1);
        write_reg(swmt_pkg::REG_TX_ENABLE, 32'd1);
        write_reg(swmt_pkg::REG_OUT_COUNT, 32'd2);
        for (int i = 0; i < 4; i++)
            push_item(ACTION_BIT, 8'h00, 1'b1);
        push_item(ACTION_BIT, 8'hFF, 1'b1);
        for (int i = 1; i < 8; i++)
            push_item(ACTION_BIT, 8'h5A, ~i[0]);
        wait_for_results;

        // Widest counts, then leave it running so the next start abandons it.
        write_reg(swmt_pkg::REG_OUT_COUNT, 32'h0000_FFFF);
        write_reg(swmt_pkg::REG_IN_OFFSET, 32'h0000_FFFF);
        write_reg(swmt_pkg::REG_IN_COUNT, 32'h0000_FFFF);
        push_item(swmt_pkg::ACTION_START, 8'h00, 1'b0);
        push_item(ACTION_BIT, 8'h00, 1'b0);
        push_item(ACTION_BIT, 8'h00, 1'b1);
        push_item(ACTION_BIT, 8'h00, 1'b0);
        wait_for_results;

        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7)
                write_reg(swmt_pkg::REG_OUT_COUNT, pick_count(4));
            if ($urandom_range(0, 9) < 7)
                write_reg(swmt_pkg::REG_IN_OFFSET, pick_count(3));
            if ($urandom_range(0, 9) < 7)
                write_reg(swmt_pkg::REG_IN_COUNT, pick_count(4));
            if ($urandom_range(0, 9) < 5)
                write_reg(swmt_pkg::REG_TX_ENABLE, $urandom_range(0, 1));
            if ($urandom_range(0, 9) < 5)
                write_reg(swmt_pkg::REG_RX_ENABLE, $urandom_range(0, 1));
            n_xfers = $urandom_range(1, 3);
            repeat (n_xfers) begin
                push_item(swmt_pkg::ACTION_START, 8'($urandom), 1'($urandom));
                counted++;
                if (shadow_cfg.tx_enable || shadow_cfg.rx_enable) begin
                    total_bytes = int'(transfer_bytes(shadow_cfg));
                    if (total_bytes > 8)
                        n_bits = $urandom_range(1, 40);
                    else if ($urandom_range(0, 99) < 85)
                        n_bits = total_bytes * 8;
                    else
                        n_bits = $urandom_range(0, total_bytes * 8);
                    repeat (n_bits) begin
                        // rare restart in the middle of a transfer
                        if ($urandom_range(0, 99) < 3)
                            push_item(swmt_pkg::ACTION_START, 8'($urandom), 1'($urandom));
                        else
                            push_item(ACTION_BIT, 8'($urandom), 1'($urandom));
                        counted++;
                    end
                end
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) push_item(ACTION_BIT, 8'($urandom), 1'($urandom));
            wait_for_results;
        end

        repeat (8) @(posedge aclk);
        if (expected_pins.size() != 0) begin
            $error("%0d expected results never arrived", expected_pins.size());
            error_count++;
        end
        $display("Checked %0d items over %0d register writes: %0d transfers done, %0d refused.",
                 results_checked, config_writes, transfers_done, starts_refused);
        $display("Window bytes received: %0d, transmit bytes taken: %0d.",
                 window_bytes, tx_bytes_taken);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
